### sv/block_cache_lru_tag_table_defines.svh
// Assertion macros shared by the block cache tag table RTL.
// Depends on nothing; files that check properties include it by name.
`ifndef BLOCK_CACHE_LRU_TAG_TABLE_DEFINES_SVH
`define BLOCK_CACHE_LRU_TAG_TABLE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define BCLRU_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tag table check failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define BCLRU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tag table check failed");

`endif

### sv/bclru_pkg.sv
// Shared types and constants of the block cache tag table.
// Used by the entry store and the top level; depends on nothing.
package bclru_pkg;

  // Default number of table entries.
  localparam int DEF_NUM_ENTRIES = 32;

  // Field widths fixed by the request and result formats.
  localparam int DEV_W   = 8;
  localparam int BLK_W   = 32;
  localparam int SLOT_W  = 5;
  localparam int TICK_W  = 32;
  localparam int COUNT_W = 8;

  // Stream payload widths.
  localparam int S_TDATA_W = 80;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 24;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hff;

  // Request commands.
  typedef enum logic [1:0] {
    CMD_GET     = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_PIN     = 2'd2,
    CMD_UNPIN   = 2'd3
  } cmd_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_NOBUF = 2'd1,
    STAT_BAD   = 2'd2
  } status_t;

  // One table entry as held in the entry memory.
  typedef struct packed {
    logic [DEV_W-1:0]   device;
    logic [BLK_W-1:0]   block;
    logic               assigned;
    logic [COUNT_W-1:0] count;
    logic [TICK_W-1:0]  last_release;
    logic               contents_valid;
  } entry_t;

  // Count plus one, held at the maximum.
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    sat_inc = (c == COUNT_MAX) ? c : c + 8'd1;
  endfunction

endpackage

### sv/bclru_entry_store.sv
// Entry memory of the block cache tag table: one registered read port,
// one write port, and per-entry written bits. Uses bclru_pkg.
module bclru_entry_store #(
  parameter int NUM_ENTRIES = bclru_pkg::DEF_NUM_ENTRIES,
  parameter int IDX_W       = $clog2(NUM_ENTRIES)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_addr,
  output bclru_pkg::entry_t   rd_data,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  bclru_pkg::entry_t   wr_data
);
  import bclru_pkg::*;

  entry_t                 mem [NUM_ENTRIES];
  entry_t                 rd_q;
  logic                   rd_written;
  logic [NUM_ENTRIES-1:0] written;

  // Entry array: synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Written bits: an entry never written reads as all zeros.
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
    end
  end

  assign rd_data = rd_written ? rd_q : '0;

endmodule

### sv/block_cache_lru_tag_table.sv
// Block cache tag table: get, release, pin and unpin on a table of entries.
// A get scans the table, reading one entry per cycle, then evaluates and responds;
// release, pin and unpin read the request slot's entry, and a bad slot goes straight to respond.
// One request is in flight at a time; the next is accepted in the cycle after the result is
// registered, which waits in the respond state while an earlier result waits for m_tready.
// Synchronous reset empties the table at once through per-entry written bits.
module block_cache_lru_tag_table #(
  parameter int NUM_ENTRIES = bclru_pkg::DEF_NUM_ENTRIES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // device[7:0], block_number[39:8], slot[44:40], now_ticks[76:45], zero fill
  input  logic [bclru_pkg::S_TDATA_W-1:0] s_tdata,
  // cmd[1:0]
  input  logic [bclru_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // result_slot[4:0], was_cached[5], needs_fill[6], status[8:7],
  // ref_count_out[16:9], zero fill
  output logic [bclru_pkg::M_TDATA_W-1:0] m_tdata
);
  import bclru_pkg::*;

  `include "block_cache_lru_tag_table_defines.svh"

  localparam int IDX_W = $clog2(NUM_ENTRIES);
  localparam int CNT_W = $clog2(NUM_ENTRIES + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_READ = 5'b00100,
    S_EVAL = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t state;

  // Request fields held for the whole operation.
  cmd_t              req_cmd;
  logic [DEV_W-1:0]  req_dev;
  logic [BLK_W-1:0]  req_blk;
  logic [SLOT_W-1:0] req_slot;
  logic [TICK_W-1:0] req_now;

  // Scan bookkeeping.
  logic [CNT_W-1:0]  iss_cnt;
  logic [IDX_W-1:0]  proc_idx;
  logic              proc_vld;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  entry_t            hit_entry;
  logic              found;
  logic [IDX_W-1:0]  best_idx;
  logic [TICK_W-1:0] best_lr;

  // Result and write-back held until the output register is free.
  logic [SLOT_W-1:0]  res_slot;
  logic               res_cached;
  logic               res_fill;
  status_t            res_status;
  logic [COUNT_W-1:0] res_count;
  logic               wb_en;
  logic [IDX_W-1:0]   wb_addr;
  entry_t             wb_data;

  // Memory port signals.
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;
  logic             wr_en;

  logic s_fire;
  logic out_free;
  logic scan_issue;
  logic scan_done;
  logic slot_bad;
  logic match;
  logic older;
  logic [COUNT_W-1:0] dec_count;

  assign s_tready   = (state == S_IDLE);
  assign s_fire     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign scan_issue = (state == S_SCAN) && (iss_cnt != CNT_W'(NUM_ENTRIES));
  assign scan_done  = (state == S_SCAN) && (iss_cnt == CNT_W'(NUM_ENTRIES)) && !proc_vld;
  assign slot_bad   = 32'(s_tdata[44:40]) >= NUM_ENTRIES;

  // Read address: the scan index during a get, the request slot otherwise.
  assign rd_en   = scan_issue || (state == S_READ);
  assign rd_addr = (state == S_SCAN) ? iss_cnt[IDX_W-1:0] : IDX_W'(req_slot);
  assign wr_en   = (state == S_RESP) && out_free && wb_en;

  // Per-entry checks on the data returned during the scan.
  assign match     = rd_data.assigned && (rd_data.device == req_dev)
                     && (rd_data.block == req_blk);
  assign older     = !found || (rd_data.last_release < best_lr);
  assign dec_count = rd_data.count - 8'd1;

  bclru_entry_store #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .IDX_W       (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wb_addr),
    .wr_data (wb_data)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      iss_cnt  <= '0;
      proc_vld <= 1'b0;
      hit      <= 1'b0;
      found    <= 1'b0;
      wb_en    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // A result becomes valid as it leaves the respond state and stays until taken.
      m_tvalid <= ((state == S_RESP) && out_free) || (m_tvalid && !m_tready);
      unique case (state)
        S_IDLE: begin
          if (s_fire) begin
            iss_cnt  <= '0;
            proc_vld <= 1'b0;
            hit      <= 1'b0;
            found    <= 1'b0;
            wb_en    <= 1'b0;
            if (cmd_t'(s_tuser) == CMD_GET) begin
              state <= S_SCAN;
            end else if (slot_bad) begin
              state <= S_RESP;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_SCAN: begin
          proc_vld <= scan_issue;
          if (scan_issue) begin
            iss_cnt <= iss_cnt + CNT_W'(1);
          end
          // Keep the first tag match and the oldest unreferenced entry.
          if (proc_vld) begin
            if (match && !hit) begin
              hit <= 1'b1;
            end
            if ((rd_data.count == '0) && older) begin
              found <= 1'b1;
            end
          end
          if (scan_done) begin
            state <= S_EVAL;
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (req_cmd == CMD_GET) begin
            wb_en <= hit || found;
          end else if (req_cmd == CMD_PIN) begin
            wb_en <= 1'b1;
          end else begin
            wb_en <= (rd_data.count != '0);
          end
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            wb_en <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers: request capture, scan capture, result forming.
  always_ff @(posedge clk) begin
    if (s_fire) begin
      req_cmd    <= cmd_t'(s_tuser);
      req_dev    <= s_tdata[7:0];
      req_blk    <= s_tdata[39:8];
      req_slot   <= s_tdata[44:40];
      req_now    <= s_tdata[76:45];
      // A bad slot answers directly from the request.
      res_slot   <= s_tdata[44:40];
      res_cached <= 1'b0;
      res_fill   <= 1'b0;
      res_status <= STAT_BAD;
      res_count  <= '0;
    end
    if ((state == S_SCAN) && proc_vld) begin
      if (match && !hit) begin
        hit_idx   <= proc_idx;
        hit_entry <= rd_data;
      end
      if ((rd_data.count == '0) && older) begin
        best_idx <= proc_idx;
        best_lr  <= rd_data.last_release;
      end
    end
    if (scan_issue) begin
      proc_idx <= iss_cnt[IDX_W-1:0];
    end
    if (state == S_EVAL) begin
      if (req_cmd == CMD_GET) begin
        if (hit) begin
          // Hit: raise the count and mark the contents filled.
          wb_addr    <= hit_idx;
          wb_data    <= {hit_entry.device, hit_entry.block, hit_entry.assigned,
                         sat_inc(hit_entry.count), hit_entry.last_release, 1'b1};
          res_slot   <= SLOT_W'(hit_idx);
          res_cached <= 1'b1;
          res_fill   <= !hit_entry.contents_valid;
          res_status <= STAT_OK;
          res_count  <= sat_inc(hit_entry.count);
        end else if (found) begin
          // Miss: retag the oldest unreferenced entry.
          wb_addr    <= best_idx;
          wb_data    <= {req_dev, req_blk, 1'b1, 8'd1, best_lr, 1'b1};
          res_slot   <= SLOT_W'(best_idx);
          res_cached <= 1'b0;
          res_fill   <= 1'b1;
          res_status <= STAT_OK;
          res_count  <= 8'd1;
        end else begin
          res_slot   <= '0;
          res_cached <= 1'b0;
          res_fill   <= 1'b0;
          res_status <= STAT_NOBUF;
          res_count  <= '0;
        end
      end else begin
        wb_addr    <= IDX_W'(req_slot);
        res_slot   <= req_slot;
        res_cached <= 1'b0;
        res_fill   <= 1'b0;
        if (req_cmd == CMD_PIN) begin
          wb_data    <= {rd_data.device, rd_data.block, rd_data.assigned,
                         sat_inc(rd_data.count), rd_data.last_release,
                         rd_data.contents_valid};
          res_status <= STAT_OK;
          res_count  <= sat_inc(rd_data.count);
        end else if (rd_data.count == '0) begin
          res_status <= STAT_BAD;
          res_count  <= '0;
        end else begin
          // Release or unpin; a final release stamps the time.
          wb_data    <= {rd_data.device, rd_data.block, rd_data.assigned, dec_count,
                         ((req_cmd == CMD_RELEASE) && (dec_count == '0)) ?
                           req_now : rd_data.last_release,
                         rd_data.contents_valid};
          res_status <= STAT_OK;
          res_count  <= dec_count;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if ((state == S_RESP) && out_free) begin
      m_tdata <= {7'd0, res_count, res_status, res_fill, res_cached, res_slot};
    end
  end

  // Checks.
  `BCLRU_ASSERT_NOW(a_rd_wr_apart, clk, rst, wr_en, !rd_en)
  `BCLRU_ASSERT_NEXT(a_one_in_flight, clk, rst, s_fire, !s_tready)
  `BCLRU_ASSERT_NOW(a_nobuf_zero, clk, rst,
    m_tvalid && (m_tdata[8:7] == STAT_NOBUF), (m_tdata[16:0] == 17'(STAT_NOBUF) << 7))
  `BCLRU_ASSERT_NOW(a_cached_ok, clk, rst,
    m_tvalid && m_tdata[5], (m_tdata[8:7] == STAT_OK) && (m_tdata[16:9] != '0))

endmodule
